// ===== design/crpm_pkg.sv =====
package crpm_pkg;

	// Fixed field and register widths
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int MODE_W        = 3;
	localparam int STATUS_W      = 2;
	localparam int MEM_BYTES_DEF = 4096;

	localparam logic [CFG_W-1:0] CHUNK_BYTES_RST = 13'd256;
	localparam logic [CFG_W-1:0] CHUNK_COUNT_RST = 13'd16;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd1;

	// Command codes
	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR   = 3'd0,
		MODE_RESERVE = 3'd1,
		MODE_COMMIT  = 3'd2,
		MODE_SIZE    = 3'd3,
		MODE_INDEX   = 3'd4,
		MODE_READ    = 3'd5
	} mode_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_ADDR   = 2'd2,
		STS_OFFSET = 2'd3
	} status_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/crpm_div.sv =====
module crpm_div
	import crpm_pkg::*;
#(
	parameter int NW = 24,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient,
	output div_stat_t     stat
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    n_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	// One restoring step: bring down the next dividend bit
	assign trial = {rem_q, n_q[NW-1]};
	assign fits  = trial >= {1'b0, divisor};

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
			n_q   <= {n_q[NW-2:0], fits};
		end
	end

	assign quotient  = n_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/chunked_ring_pointer_manager.sv =====
// Channel  Dir  Handshake              Payload
// s        in   s_tvalid / s_tready    tuser: mode; tdata: address, offset, max_bytes
// m        out  m_tvalid / m_tready    tdata: grant_addr .. no_data
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command per cycle while m_tready is high; each result beat is registered before m_tvalid.
// The commit rounding runs through two registered multiplies; the ring update,
// fill, locate and read plan sit in one stage after them.
// After reset and after each register write the block recomputes its chunk
// sizes with a shared bit-serial divider, during which s_tready is low;
// config writes are always taken.
// A stalled m side backs the pipeline up stage by stage, then drops s_tready.
module chunked_ring_pointer_manager
	import crpm_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                s_tvalid,
	output logic                                                s_tready,
	// address, offset, max_bytes (from bit 0 up)
	input  logic [(($clog2(MEM_BYTES) + 2*$clog2(MEM_BYTES+1) + 7) / 8)*8-1:0] s_tdata,
	// mode
	input  logic [MODE_W-1:0]                                   s_tuser,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	// grant_addr, fill_bytes, position, status, first_addr, first_len,
	// second_len, no_data (from bit 0 up)
	output logic [((3*$clog2(MEM_BYTES) + 4*$clog2(MEM_BYTES+1) + STATUS_W + 1 + 7) / 8)*8-1:0]
	                                                            m_tdata,
	input  logic                                                cfg_valid,
	output logic                                                cfg_ready,
	input  logic [CFG_IDX_W-1:0]                                cfg_index,
	input  logic [CFG_W-1:0]                                    cfg_data
);

	localparam int AW     = $clog2(MEM_BYTES);
	localparam int LW     = $clog2(MEM_BYTES + 1);
	localparam int K      = 2 * AW;
	localparam int MW     = K + 1;
	localparam int CMP_W  = (CFG_W > LW) ? CFG_W : LW;
	localparam int QW     = LW + 2;
	localparam int OUT_B  = 3*AW + 4*LW + STATUS_W + 1;
	localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;

	typedef enum logic [5:0] {
		SQ_LIM_GO   = 6'b000001,
		SQ_LIM_WAIT = 6'b000010,
		SQ_RCP_GO   = 6'b000100,
		SQ_RCP_WAIT = 6'b001000,
		SQ_SPAN     = 6'b010000,
		SQ_RUN      = 6'b100000
	} seq_t;

	seq_t             seq_q;
	logic [CFG_W-1:0] cb_q;
	logic [CFG_W-1:0] cc_q;
	logic [LW-1:0]    lim_q;
	logic [MW-1:0]    m_q;
	logic [LW-1:0]    span_q;
	logic             cfg_wr;

	logic [CMP_W-1:0] cb_ext;
	logic [CMP_W-1:0] cc_ext;
	logic [CMP_W-1:0] cc_one;
	logic [LW-1:0]    cbe;
	logic [LW-1:0]    cce;
	logic [2*LW-1:0]  span_prod;

	logic             div_start;
	logic [K-1:0]     div_dividend;
	logic [K-1:0]     div_quot;
	div_stat_t        div_stat;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid &&
		(cfg_index == REG_CHUNK_BYTES || cfg_index == REG_CHUNK_COUNT);

	// Hold the config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= CHUNK_BYTES_RST;
			cc_q <= CHUNK_COUNT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CHUNK_BYTES) cb_q <= cfg_data;
			if (cfg_index == REG_CHUNK_COUNT) cc_q <= cfg_data;
		end
	end

	// Clamp chunk size and count to what fits
	always_comb begin
		cb_ext = CMP_W'(cb_q);
		cc_ext = CMP_W'(cc_q);
		if (cb_ext == '0)
			cbe = LW'(1);
		else if (cb_ext > CMP_W'(MEM_BYTES))
			cbe = LW'(MEM_BYTES);
		else
			cbe = LW'(cb_ext);
		cc_one = (cc_ext == '0) ? CMP_W'(1) : cc_ext;
		cce    = (cc_one > CMP_W'(lim_q)) ? lim_q : LW'(cc_one);
	end

	assign span_prod    = {{LW{1'b0}}, cbe} * {{LW{1'b0}}, cce};
	assign div_start    = (seq_q == SQ_LIM_GO) || (seq_q == SQ_RCP_GO);
	assign div_dividend = (seq_q == SQ_LIM_GO) ? K'(MEM_BYTES) : {K{1'b1}};

	crpm_div #(
		.NW(K),
		.DW(LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cbe),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// Sequence the size recompute after reset and register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_LIM_GO;
		end else if (cfg_wr) begin
			seq_q <= SQ_LIM_GO;
		end else begin
			unique case (seq_q)
				SQ_LIM_GO:   seq_q <= SQ_LIM_WAIT;
				SQ_LIM_WAIT: if (div_stat.done) seq_q <= SQ_RCP_GO;
				SQ_RCP_GO:   seq_q <= SQ_RCP_WAIT;
				SQ_RCP_WAIT: if (div_stat.done) seq_q <= SQ_SPAN;
				SQ_SPAN:     seq_q <= SQ_RUN;
				SQ_RUN:      seq_q <= SQ_RUN;
				default:     seq_q <= SQ_LIM_GO;
			endcase
		end
	end

	// Capture chunk limit, reciprocal and span
	always_ff @(posedge clk) begin
		if (seq_q == SQ_LIM_WAIT && div_stat.done) lim_q <= div_quot[LW-1:0];
		if (seq_q == SQ_RCP_WAIT && div_stat.done) m_q <= {1'b0, div_quot} + MW'(1);
		if (seq_q == SQ_SPAN) span_q <= span_prod[LW-1:0];
	end

	// ---------------- command pipeline ----------------
	logic              v1_q, v2_q, v3_q, vo_q;
	logic              r1, r2, r3;
	logic              s_fire;
	logic [MODE_W-1:0] mode_s1, mode_s2, mode_s3;
	logic [AW-1:0]     addr_s1, addr_s2, addr_s3;
	logic [LW-1:0]     off_s1, off_s2, off_s3;
	logic [LW-1:0]     maxb_s1, maxb_s2, maxb_s3;
	logic [AW-1:0]     quo_s2;
	logic [AW-1:0]     base_s3;
	logic [AW+MW-1:0]  prod1;
	logic [AW+LW-1:0]  prod2;

	assign r3       = !vo_q || m_tready;
	assign r2       = !v3_q || r3;
	assign r1       = !v2_q || r2;
	assign s_tready = (seq_q == SQ_RUN) && (!v1_q || r1);
	assign s_fire   = s_tvalid && s_tready;

	// Quotient of address by chunk size via the reciprocal
	assign prod1 = {{MW{1'b0}}, addr_s1} * {{AW{1'b0}}, m_q};
	// Back to a chunk start
	assign prod2 = {{LW{1'b0}}, quo_s2} * {{AW{1'b0}}, cbe};

	// Advance the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (!v1_q || r1) v1_q <= s_fire;
			if (r1) v2_q <= v1_q;
			if (r2) v3_q <= v2_q;
		end
	end

	// Move the stage payloads
	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_s1 <= s_tuser;
			addr_s1 <= s_tdata[AW-1:0];
			off_s1  <= s_tdata[AW+LW-1:AW];
			maxb_s1 <= s_tdata[AW+2*LW-1:AW+LW];
		end
		if (v1_q && r1) begin
			mode_s2 <= mode_s1;
			addr_s2 <= addr_s1;
			off_s2  <= off_s1;
			maxb_s2 <= maxb_s1;
			quo_s2  <= prod1[K+AW-1:K];
		end
		if (v2_q && r2) begin
			mode_s3 <= mode_s2;
			addr_s3 <= addr_s2;
			off_s3  <= off_s2;
			maxb_s3 <= maxb_s2;
			base_s3 <= prod2[AW-1:0];
		end
	end

	// ---------------- ring state and result ----------------
	logic [AW-1:0]  oldest_q, newest_q, nf_q;
	logic           holds_q;
	logic           fire3;

	logic [AW-1:0]  n_old, n_new, n_nf;
	logic           n_hold;
	logic [LW:0]    nf_sum, oc_sum;
	logic [AW-1:0]  nf_wrap;
	logic [LW-1:0]  a_l, o_l, nw_l, r_l;
	logic           pv;
	logic [LW-1:0]  p;
	logic [LW-1:0]  fill_cur;
	logic [QW-1:0]  qs;
	logic           q_ok;
	logic [LW:0]    r_sum;
	logic [AW-1:0]  r;
	logic [LW-1:0]  run_len, low_len, rest_len;

	logic [AW-1:0]  o_chunk, o_faddr;
	logic [LW-1:0]  o_pos, o_flen, o_slen, o_fill;
	status_t        o_sts;

	assign fire3 = v3_q && r3;

	function automatic logic [LW-1:0] fill_of(input logic h, input logic [AW-1:0] o,
			input logic [AW-1:0] n, input logic [LW-1:0] sp);
		logic [LW:0] t;
		if (!h)
			t = '0;
		else if (n >= o)
			t = {1'b0, LW'(n)} - {1'b0, LW'(o)} + (LW+1)'(1);
		else
			t = {1'b0, sp} - {1'b0, LW'(o)} + {1'b0, LW'(n)} + (LW+1)'(1);
		return t[LW-1:0];
	endfunction

	// Work out one command against the ring
	always_comb begin
		n_old  = oldest_q;
		n_new  = newest_q;
		n_nf   = nf_q;
		n_hold = holds_q;

		o_chunk = '0;
		o_pos   = '0;
		o_sts   = STS_OK;
		o_faddr = '0;
		o_flen  = '0;
		o_slen  = '0;

		a_l  = LW'(addr_s3);
		o_l  = LW'(oldest_q);
		nw_l = LW'(newest_q);

		// Reserve arithmetic
		nf_sum  = {1'b0, LW'(nf_q)} + {1'b0, cbe};
		nf_wrap = (nf_sum >= {1'b0, span_q}) ? '0 : nf_sum[AW-1:0];
		oc_sum  = {1'b0, o_l} + {1'b0, cbe};

		// Locate the address in the valid data
		pv = 1'b0;
		p  = '0;
		if (!holds_q || a_l >= span_q) begin
			pv = 1'b0;
		end else if (newest_q >= oldest_q) begin
			pv = (addr_s3 >= oldest_q) && (addr_s3 <= newest_q);
			p  = a_l - o_l;
		end else if (addr_s3 >= oldest_q) begin
			pv = 1'b1;
			p  = a_l - o_l;
		end else if (addr_s3 <= newest_q) begin
			pv = 1'b1;
			p  = span_q - o_l + a_l;
		end

		fill_cur = fill_of(holds_q, oldest_q, newest_q, span_q);

		// Move by the offset and resolve the segments
		qs       = {2'b00, p} + {{2{off_s3[LW-1]}}, off_s3};
		q_ok     = !qs[QW-1] && (qs[LW:0] < {1'b0, fill_cur});
		r_sum    = {1'b0, o_l} + {1'b0, qs[LW-1:0]};
		r        = (r_sum >= {1'b0, span_q}) ? AW'(r_sum - {1'b0, span_q}) : r_sum[AW-1:0];
		r_l      = LW'(r);
		low_len  = nw_l + LW'(1);
		run_len  = '0;
		rest_len = '0;

		unique case (mode_s3)
			MODE_CLEAR: begin
				n_old  = '0;
				n_new  = '0;
				n_nf   = '0;
				n_hold = 1'b0;
			end
			MODE_RESERVE: begin
				o_chunk = nf_q;
				n_nf    = nf_wrap;
				if (holds_q && nf_q == oldest_q) begin
					if (newest_q >= oldest_q && {1'b0, nw_l} < oc_sum) begin
						n_hold = 1'b0;
						n_old  = '0;
						n_new  = '0;
					end else begin
						n_old = nf_wrap;
					end
				end
			end
			MODE_COMMIT: begin
				if (LW'(base_s3) < span_q) begin
					if (!holds_q) n_old = base_s3;
					n_new  = AW'(LW'(base_s3) + cbe - LW'(1));
					n_hold = 1'b1;
				end
			end
			MODE_INDEX: begin
				o_pos = pv ? p : '1;
				if (!holds_q)
					o_sts = STS_EMPTY;
				else if (!pv)
					o_sts = STS_ADDR;
			end
			MODE_READ: begin
				if (!holds_q) begin
					o_sts = STS_EMPTY;
				end else if (!pv) begin
					o_sts = STS_ADDR;
				end else if (!q_ok) begin
					o_sts = STS_OFFSET;
				end else begin
					o_faddr = r;
					if (newest_q < oldest_q && r >= oldest_q) begin
						run_len  = span_q - r_l;
						o_flen   = (run_len < maxb_s3) ? run_len : maxb_s3;
						rest_len = maxb_s3 - o_flen;
						o_slen   = (low_len < rest_len) ? low_len : rest_len;
					end else begin
						run_len = nw_l - r_l + LW'(1);
						o_flen  = (run_len < maxb_s3) ? run_len : maxb_s3;
					end
				end
			end
			default: begin
				// size query and unused codes leave the ring alone
			end
		endcase

		o_fill = fill_of(n_hold, n_old, n_new, span_q);
	end

	// Update the ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			newest_q <= '0;
			nf_q     <= '0;
			holds_q  <= 1'b0;
		end else if (cfg_wr) begin
			oldest_q <= '0;
			newest_q <= '0;
			nf_q     <= '0;
			holds_q  <= 1'b0;
		end else if (fire3) begin
			oldest_q <= n_old;
			newest_q <= n_new;
			nf_q     <= n_nf;
			holds_q  <= n_hold;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vo_q <= 1'b0;
		else if (r3)
			vo_q <= v3_q;
	end

	always_ff @(posedge clk) begin
		if (fire3)
			m_tdata <= OUT_W'({!n_hold, o_slen, o_flen, o_faddr, o_sts, o_pos, o_fill, o_chunk});
	end

	assign m_tvalid = vo_q;

	// ---------------- checks ----------------
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !holds_q && nf_q == '0)
		else $error("register write did not clear the ring");

	a_nf_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_RUN |-> LW'(nf_q) < span_q)
		else $error("next free chunk beyond span");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		!holds_q |-> oldest_q == '0 && newest_q == '0)
		else $error("empty ring with stale pointers");

	a_ptrs_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_RUN && holds_q |-> LW'(oldest_q) < span_q && LW'(newest_q) < span_q)
		else $error("ring pointer beyond span");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SQ_RUN |-> !div_stat.busy)
		else $error("size divider busy while commands are taken");

endmodule
